>>> hw/rtl/ntsp_pkg.sv
package ntsp_pkg;

   localparam int CoordBits  = 24;
   localparam int MaxTiles   = 32;
   localparam int TileBits   = 5;
   localparam int CountBits  = 6;
   localparam int RadiusBits = 24;
   localparam int PhaseBits  = 8;
   localparam int OpBits     = CoordBits + 1;
   localparam int SqBits     = 2 * OpBits;
   localparam int DistBits   = SqBits + 2;
   localparam int ScaledBits = DistBits + 7;
   localparam int CsrIdxBits = 2;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;
   localparam logic [1:0] CMD_FINISH = 2'd3;

   localparam logic [2:0] ACT_DONE     = 3'd0;
   localparam logic [2:0] ACT_UNLOAD   = 3'd1;
   localparam logic [2:0] ACT_BEGIN    = 3'd2;
   localparam logic [2:0] ACT_LOADED   = 3'd3;
   localparam logic [2:0] ACT_DROPPED  = 3'd4;
   localparam logic [2:0] ACT_REJECTED = 3'd5;

   localparam logic [CsrIdxBits-1:0] CSR_LOAD_RADIUS   = 2'd0;
   localparam logic [CsrIdxBits-1:0] CSR_UNLOAD_RADIUS = 2'd1;
   localparam logic [CsrIdxBits-1:0] CSR_ASYNC_LOAD    = 2'd2;
   localparam logic [CsrIdxBits-1:0] CSR_UPDATE_EVERY  = 2'd3;

   typedef struct packed {
      logic [1:0]                  command;
      logic signed [CoordBits-1:0] pos_x;
      logic signed [CoordBits-1:0] pos_y;
      logic signed [CoordBits-1:0] pos_z;
      logic                        view_valid;
      logic                        asset_present;
      logic [TileBits-1:0]         tile_index;
   } req_type;

   typedef struct packed {
      logic [2:0]          action;
      logic [TileBits-1:0] target_tile;
      logic                last_of_run;
   } rsp_type;

   typedef struct packed {
      logic signed [CoordBits-1:0] x;
      logic signed [CoordBits-1:0] y;
      logic signed [CoordBits-1:0] z;
   } pos_type;

endpackage

>>> hw/rtl/nearest_tile_stream_policy.sv
// nearest-tile streaming policy. a command word is taken when start is high and busy is low;
// the block then stays busy until its closing done word, which is on rsp_data with
// last_of_run set in the cycle busy drops. every result word is shown for exactly one cycle
// on rsp_valid and cannot be held off. one shared squarer works out all distances, one axis
// per cycle, so cost is set by the sequencer: a clear steps through the table, a finish may
// take a distance check, and a tick that does work makes two passes over the table, taking
// a distance for each tile that a pass does not skip, plus a synchronous finish; a tick may
// also reduce the phase by repeated subtraction (only after update_every is lowered)
module nearest_tile_stream_policy (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  ntsp_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output ntsp_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [ntsp_pkg::CsrIdxBits-1:0]  csr_index,
   input  logic [ntsp_pkg::RadiusBits-1:0]  csr_wdata
);
   import ntsp_pkg::*;

   // sequencer states
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_CLR  = 4'd1;
   localparam logic [3:0] ST_PH   = 4'd2;
   localparam logic [3:0] ST_L2   = 4'd3;
   localparam logic [3:0] ST_U2   = 4'd4;
   localparam logic [3:0] ST_R2   = 4'd5;
   localparam logic [3:0] ST_SCAN = 4'd6;
   localparam logic [3:0] ST_MX   = 4'd7;
   localparam logic [3:0] ST_MY   = 4'd8;
   localparam logic [3:0] ST_MZ   = 4'd9;
   localparam logic [3:0] ST_ACC  = 4'd10;
   localparam logic [3:0] ST_CMP  = 4'd11;
   localparam logic [3:0] ST_PICK = 4'd12;
   localparam logic [3:0] ST_FIN  = 4'd13;
   localparam logic [3:0] ST_DONE = 4'd14;

   // what a distance is taken for
   localparam logic [1:0] CTX_UNLOAD = 2'd0;
   localparam logic [1:0] CTX_NEAR   = 2'd1;
   localparam logic [1:0] CTX_FIN    = 2'd2;

   localparam logic [CountBits-1:0] CountFull = CountBits'(MaxTiles);

   // configuration
   logic [RadiusBits-1:0] load_radius_ff, unload_radius_ff;
   logic                  async_load_ff;
   logic [PhaseBits-1:0]  update_every_ff;

   // control state
   logic [3:0]            state_ff, state_in;
   logic [1:0]            ctx_ff, ctx_in;
   logic [CountBits-1:0]  count_ff, count_in;
   logic [CountBits-1:0]  idx_ff, idx_in;
   logic [PhaseBits-1:0]  phase_ff, phase_in;
   logic [MaxTiles-1:0]   loaded_ff, loaded_in;
   logic [MaxTiles-1:0]   loading_ff, loading_in;
   logic [MaxTiles-1:0]   asset_ff, asset_in;
   logic                  found_ff, found_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload registers
   pos_type               view_ff, view_in;
   logic                  vvalid_ff, vvalid_in;
   logic [TileBits-1:0]   best_ff, best_in;
   logic [DistBits-1:0]   best_d_ff, best_d_in;
   logic [DistBits-1:0]   acc_ff, acc_in;
   logic [SqBits-1:0]     l2_ff, l2_in;
   logic [SqBits-1:0]     u2_ff, u2_in;
   logic [ScaledBits-1:0] l2s_ff, l2s_in;
   rsp_type               rsp_ff, rsp_in;

   // datapath
   logic                  ram_we;
   pos_type               ram_wdata;
   pos_type               ram_rdata;
   logic signed [OpBits-1:0] op_a, op_b;
   logic [SqBits-1:0]     sq;
   logic [TileBits-1:0]   cur;
   logic [ScaledBits-1:0] d_scaled;
   logic                  accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign cur    = idx_ff[TileBits-1:0];

   // tile positions: written on append, read at the scan index
   ntsp_ram #(
      .Width($bits(pos_type)),
      .Depth(MaxTiles)
   ) u_pos_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(count_ff[TileBits-1:0]),
      .wdata(ram_wdata),
      .raddr(cur),
      .rdata(ram_rdata)
   );

   ntsp_sq u_sq (
      .clock(clock),
      .op_a(op_a),
      .op_b(op_b),
      .sq(sq)
   );

   // squarer operands per step
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ST_L2: op_a = OpBits'({1'b0, load_radius_ff});
         ST_U2: op_a = OpBits'({1'b0, unload_radius_ff});
         ST_MX: begin
            op_a = {ram_rdata.x[CoordBits-1], ram_rdata.x};
            op_b = {view_ff.x[CoordBits-1], view_ff.x};
         end
         ST_MY: begin
            op_a = {ram_rdata.y[CoordBits-1], ram_rdata.y};
            op_b = {view_ff.y[CoordBits-1], view_ff.y};
         end
         ST_MZ: begin
            op_a = {ram_rdata.z[CoordBits-1], ram_rdata.z};
            op_b = {view_ff.z[CoordBits-1], view_ff.z};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // 100 * d as shifts
   assign d_scaled = (ScaledBits'(acc_ff) << 6) + (ScaledBits'(acc_ff) << 5)
                   + (ScaledBits'(acc_ff) << 2);

   always_comb begin
      state_in     = state_ff;
      ctx_in       = ctx_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      phase_in     = phase_ff;
      loaded_in    = loaded_ff;
      loading_in   = loading_ff;
      asset_in     = asset_ff;
      found_in     = found_ff;
      view_in      = view_ff;
      vvalid_in    = vvalid_ff;
      best_in      = best_ff;
      best_d_in    = best_d_ff;
      acc_in       = acc_ff;
      l2_in        = l2_ff;
      u2_in        = u2_ff;
      l2s_in       = l2s_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      ram_we       = 1'b0;
      ram_wdata.x  = req_data.pos_x;
      ram_wdata.y  = req_data.pos_y;
      ram_wdata.z  = req_data.pos_z;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               view_in.x = req_data.pos_x;
               view_in.y = req_data.pos_y;
               view_in.z = req_data.pos_z;
               vvalid_in = req_data.view_valid;
               idx_in    = CountBits'(req_data.tile_index);
               state_in  = ST_DONE;
               unique case (req_data.command)
                  CMD_CLEAR: begin
                     idx_in   = '0;
                     state_in = ST_CLR;
                  end
                  CMD_APPEND: begin
                     if (count_ff < CountFull) begin
                        ram_we                               = 1'b1;
                        loaded_in[count_ff[TileBits-1:0]]    = 1'b0;
                        loading_in[count_ff[TileBits-1:0]]   = 1'b0;
                        asset_in[count_ff[TileBits-1:0]]     = req_data.asset_present;
                        count_in                             = count_ff + 1'b1;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.action = ACT_REJECTED;
                     end
                  end
                  CMD_TICK: state_in = ST_PH;
                  CMD_FINISH: begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.target_tile = req_data.tile_index;
                     if (CountBits'(req_data.tile_index) >= count_ff) begin
                        rsp_in.action = ACT_REJECTED;
                     end else if (!asset_ff[req_data.tile_index]
                                  || loaded_ff[req_data.tile_index]) begin
                        loading_in[req_data.tile_index] = 1'b0;
                        rsp_in.action                   = ACT_REJECTED;
                     end else if (!req_data.view_valid) begin
                        loading_in[req_data.tile_index] = 1'b0;
                        loaded_in[req_data.tile_index]  = 1'b1;
                        rsp_in.action                   = ACT_LOADED;
                     end else begin
                        // distance check needed
                        rsp_valid_in = 1'b0;
                        ctx_in       = CTX_FIN;
                        state_in     = ST_L2;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end

         ST_CLR: begin
            if (idx_ff >= count_ff) begin
               loaded_in  = '0;
               loading_in = '0;
               asset_in   = '0;
               count_in   = '0;
               state_in   = ST_DONE;
            end else begin
               if (loaded_ff[cur]) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.action      = ACT_UNLOAD;
                  rsp_in.target_tile = cur;
               end
               idx_in = idx_ff + 1'b1;
            end
         end

         // reduce the phase by repeated subtraction, then step it
         ST_PH: begin
            if (update_every_ff <= PhaseBits'(1)) begin
               state_in = (count_ff != '0 && vvalid_ff) ? ST_L2 : ST_DONE;
               ctx_in   = CTX_UNLOAD;
            end else if (phase_ff >= update_every_ff) begin
               phase_in = phase_ff - update_every_ff;
            end else begin
               phase_in = (phase_ff + 1'b1 == update_every_ff) ? '0 : phase_ff + 1'b1;
               state_in = (phase_ff == '0 && count_ff != '0 && vvalid_ff) ? ST_L2 : ST_DONE;
               ctx_in   = CTX_UNLOAD;
            end
         end

         ST_L2: state_in = ST_U2;

         ST_U2: begin
            l2_in    = sq;
            state_in = ST_R2;
         end

         ST_R2: begin
            u2_in  = sq;
            l2s_in = (ScaledBits'(l2_ff) << 7) - (ScaledBits'(l2_ff) << 3)
                   + ScaledBits'(l2_ff);
            if (ctx_ff == CTX_FIN) begin
               state_in = ST_MX;
            end else begin
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (idx_ff >= count_ff) begin
               if (ctx_ff == CTX_UNLOAD) begin
                  ctx_in    = CTX_NEAR;
                  idx_in    = '0;
                  found_in  = 1'b0;
                  best_d_in = DistBits'(l2_ff);
               end else begin
                  state_in = ST_PICK;
               end
            end else if (ctx_ff == CTX_UNLOAD ? loaded_ff[cur]
                                             : !(loaded_ff[cur] || loading_ff[cur])) begin
               state_in = ST_MX;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_MX: state_in = ST_MY;

         ST_MY: begin
            acc_in   = DistBits'(sq);
            state_in = ST_MZ;
         end

         ST_MZ: begin
            acc_in   = acc_ff + DistBits'(sq);
            state_in = ST_ACC;
         end

         ST_ACC: begin
            acc_in   = acc_ff + DistBits'(sq);
            state_in = ST_CMP;
         end

         ST_CMP: begin
            unique case (ctx_ff)
               CTX_UNLOAD: begin
                  if (acc_ff > DistBits'(u2_ff) && d_scaled > l2s_ff) begin
                     loaded_in[cur]     = 1'b0;
                     loading_in[cur]    = 1'b0;
                     rsp_valid_in       = 1'b1;
                     rsp_in.action      = ACT_UNLOAD;
                     rsp_in.target_tile = cur;
                  end
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SCAN;
               end
               CTX_NEAR: begin
                  if (acc_ff <= best_d_ff) begin
                     best_d_in = acc_ff;
                     best_in   = cur;
                     found_in  = 1'b1;
                  end
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SCAN;
               end
               default: begin
                  best_d_in = acc_ff;
                  state_in  = ST_FIN;
               end
            endcase
         end

         ST_PICK: begin
            state_in = ST_DONE;
            if (found_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_in.target_tile = best_ff;
               if (!asset_ff[best_ff]) begin
                  rsp_in.action = ACT_REJECTED;
               end else begin
                  rsp_in.action = ACT_BEGIN;
                  if (async_load_ff) begin
                     loading_in[best_ff] = 1'b1;
                  end else begin
                     // synchronous load finishes against the tick's view
                     idx_in   = CountBits'(best_ff);
                     state_in = ST_FIN;
                  end
               end
            end
         end

         ST_FIN: begin
            loading_in[cur]    = 1'b0;
            rsp_valid_in       = 1'b1;
            rsp_in.target_tile = cur;
            if (!asset_ff[cur] || loaded_ff[cur]) begin
               rsp_in.action = ACT_REJECTED;
            end else if (best_d_ff > DistBits'(u2_ff)) begin
               rsp_in.action = ACT_DROPPED;
            end else begin
               loaded_in[cur] = 1'b1;
               rsp_in.action  = ACT_LOADED;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            rsp_valid_in       = 1'b1;
            rsp_in.action      = ACT_DONE;
            rsp_in.last_of_run = 1'b1;
            state_in           = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         ctx_ff           <= CTX_UNLOAD;
         count_ff         <= '0;
         idx_ff           <= '0;
         phase_ff         <= '0;
         loaded_ff        <= '0;
         loading_ff       <= '0;
         asset_ff         <= '0;
         found_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         load_radius_ff   <= '0;
         unload_radius_ff <= '0;
         async_load_ff    <= 1'b1;
         update_every_ff  <= PhaseBits'(1);
      end else begin
         state_ff     <= state_in;
         ctx_ff       <= ctx_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         loaded_ff    <= loaded_in;
         loading_ff   <= loading_in;
         asset_ff     <= asset_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_LOAD_RADIUS:   load_radius_ff   <= csr_wdata;
               CSR_UNLOAD_RADIUS: unload_radius_ff <= csr_wdata;
               CSR_ASYNC_LOAD:    async_load_ff    <= csr_wdata[0];
               CSR_UPDATE_EVERY:  update_every_ff  <= csr_wdata[PhaseBits-1:0];
               default:           async_load_ff    <= async_load_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      view_ff   <= view_in;
      vvalid_ff <= vvalid_in;
      best_ff   <= best_in;
      best_d_ff <= best_d_in;
      acc_ff    <= acc_in;
      l2_ff     <= l2_in;
      u2_ff     <= u2_in;
      l2s_ff    <= l2s_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hw/rtl/ntsp_ram.sv
module ntsp_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/ntsp_sq.sv
// shared squarer: |a - b|^2, registered
module ntsp_sq (
   input  logic                             clock,
   input  logic signed [ntsp_pkg::OpBits-1:0] op_a,
   input  logic signed [ntsp_pkg::OpBits-1:0] op_b,
   output logic [ntsp_pkg::SqBits-1:0]      sq
);
   import ntsp_pkg::*;

   logic signed [OpBits:0] diff;
   logic [OpBits-1:0]      mag;
   logic [SqBits-1:0]      sq_ff;
   logic [SqBits-1:0]      sq_in;

   always_comb begin
      diff = {op_a[OpBits-1], op_a} - {op_b[OpBits-1], op_b};
      mag  = diff[OpBits] ? OpBits'(-diff) : diff[OpBits-1:0];
      sq_in = mag * mag;
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

   assign sq = sq_ff;

endmodule

>>> hw/rtl/ntsp_checker.sv
module ntsp_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input ntsp_pkg::rsp_type rsp_data
);
   import ntsp_pkg::*;

   // a taken command keeps the block busy
   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("accepted command did not raise busy");

   // the closing word ends the busy period
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_run |-> !busy)
      else $error("closing word while still busy");

   // done words always close the run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action == ACT_DONE |-> rsp_data.last_of_run)
      else $error("done word without last_of_run");

   // done words carry no tile
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_run |-> rsp_data.target_tile == '0)
      else $error("closing word with a tile");

endmodule

bind nearest_tile_stream_policy ntsp_checker u_ntsp_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_data(rsp_data)
);

>>> test/nearest_tile_stream_policy_tb.sv
module nearest_tile_stream_policy_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ntsp_pkg::*;

   localparam int CycleLimit = 3000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CsrIdxBits-1:0] csr_index = CSR_LOAD_RADIUS;
   logic [RadiusBits-1:0] csr_wdata = '0;

   nearest_tile_stream_policy u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // command words waiting to be driven and result words still owed
   req_type cmd_queue[$];
   rsp_type owed_words[$];

   int error_count = 0;
   int cmds_taken  = 0;
   int words_seen  = 0;
   int cycle_count = 0;
   bit no_gaps     = 1'b0;

   // shadow of the policy state
   logic [RadiusBits-1:0]       sh_load_radius   = '0;
   logic [RadiusBits-1:0]       sh_unload_radius = '0;
   logic                        sh_async         = 1'b1;
   logic [PhaseBits-1:0]        sh_every         = 8'd1;
   logic signed [CoordBits-1:0] sh_x [MaxTiles];
   logic signed [CoordBits-1:0] sh_y [MaxTiles];
   logic signed [CoordBits-1:0] sh_z [MaxTiles];
   logic [MaxTiles-1:0]         sh_loaded  = '0;
   logic [MaxTiles-1:0]         sh_loading = '0;
   logic [MaxTiles-1:0]         sh_asset   = '0;
   int                          sh_count   = 0;
   int                          sh_phase   = 0;

   task automatic report(input string what);
      error_count++;
      $display("mismatch @%0t: %s", $realtime, what);
   endtask

   function automatic void owe(input logic [2:0] act, input int tile, input logic last);
      rsp_type w;
      w.action      = act;
      w.target_tile = tile[TileBits-1:0];
      w.last_of_run = last;
      owed_words.push_back(w);
   endfunction

   // exact squared distance; 24 bit coordinates never reach the clamps
   function automatic longint tile_dist2(input int i, input logic signed [CoordBits-1:0] vx,
                                         input logic signed [CoordBits-1:0] vy,
                                         input logic signed [CoordBits-1:0] vz);
      longint dx, dy, dz;
      dx = longint'(sh_x[i]) - longint'(vx);
      dy = longint'(sh_y[i]) - longint'(vy);
      dz = longint'(sh_z[i]) - longint'(vz);
      return dx * dx + dy * dy + dz * dz;
   endfunction

   function automatic void finish_load(input int i, input req_type r);
      longint u2;
      u2 = longint'(sh_unload_radius) * longint'(sh_unload_radius);
      sh_loading[i] = 1'b0;
      if (!sh_asset[i] || sh_loaded[i]) begin
         owe(ACT_REJECTED, i, 1'b0);
      end else if (r.view_valid && tile_dist2(i, r.pos_x, r.pos_y, r.pos_z) > u2) begin
         owe(ACT_DROPPED, i, 1'b0);
      end else begin
         sh_loaded[i] = 1'b1;
         owe(ACT_LOADED, i, 1'b0);
      end
   endfunction

   function automatic void stream_tick(input req_type r);
      longint l2, u2, d, best_d;
      int best;
      l2 = longint'(sh_load_radius) * longint'(sh_load_radius);
      u2 = longint'(sh_unload_radius) * longint'(sh_unload_radius);
      best_d = l2;
      best = -1;
      // release pass against the unload radius and the widened load radius
      for (int i = 0; i < sh_count; i++) begin
         if (sh_loaded[i]) begin
            d = tile_dist2(i, r.pos_x, r.pos_y, r.pos_z);
            if (d > u2 && 100 * d > 121 * l2) begin
               sh_loaded[i]  = 1'b0;
               sh_loading[i] = 1'b0;
               owe(ACT_UNLOAD, i, 1'b0);
            end
         end
      end
      // nearest idle tile, later index wins a tie
      for (int i = 0; i < sh_count; i++) begin
         if (!sh_loaded[i] && !sh_loading[i]) begin
            d = tile_dist2(i, r.pos_x, r.pos_y, r.pos_z);
            if (d <= best_d) begin
               best_d = d;
               best = i;
            end
         end
      end
      if (best >= 0) begin
         if (!sh_asset[best]) begin
            owe(ACT_REJECTED, best, 1'b0);
         end else begin
            owe(ACT_BEGIN, best, 1'b0);
            if (sh_async) sh_loading[best] = 1'b1;
            else finish_load(best, r);
         end
      end
   endfunction

   function automatic void policy_step(input req_type r);
      bit run;
      int ph;
      run = 1'b1;
      case (r.command)
         CMD_CLEAR: begin
            for (int i = 0; i < sh_count; i++)
               if (sh_loaded[i]) owe(ACT_UNLOAD, i, 1'b0);
            sh_loaded  = '0;
            sh_loading = '0;
            sh_asset   = '0;
            sh_count   = 0;
         end
         CMD_APPEND: begin
            if (sh_count < MaxTiles) begin
               sh_x[sh_count] = r.pos_x;
               sh_y[sh_count] = r.pos_y;
               sh_z[sh_count] = r.pos_z;
               sh_loaded[sh_count]  = 1'b0;
               sh_loading[sh_count] = 1'b0;
               sh_asset[sh_count]   = r.asset_present;
               sh_count++;
            end else begin
               owe(ACT_REJECTED, 0, 1'b0);
            end
         end
         CMD_TICK: begin
            // divided tick: only phase zero does work
            if (sh_every > 1) begin
               ph = sh_phase % int'(sh_every);
               sh_phase = (ph + 1) % int'(sh_every);
               run = (ph == 0);
            end
            if (run && sh_count > 0 && r.view_valid) stream_tick(r);
         end
         default: begin
            if (int'(r.tile_index) < sh_count) finish_load(int'(r.tile_index), r);
            else owe(ACT_REJECTED, int'(r.tile_index), 1'b0);
         end
      endcase
      owe(ACT_DONE, 0, 1'b1);
   endfunction

   // driver: word taken when start is high and busy is low
   always @(posedge clock) begin
      bit taken;
      int gap;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            policy_step(req_data);
            cmds_taken++;
         end
         if (start && !taken) begin
            // hold the word until busy drops
         end else if (gap > 0) begin
            gap--;
            start <= 1'b0;
         end else if (cmd_queue.size() != 0) begin
            req_data <= cmd_queue.pop_front();
            start <= 1'b1;
            gap = no_gaps ? 0 : $urandom_range(0, 11);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every valid word is checked against the oldest owed word
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid) begin
         words_seen++;
         if (owed_words.size() == 0) begin
            report($sformatf("unexpected word act=%0d tile=%0d last=%0b",
                             rsp_data.action, rsp_data.target_tile, rsp_data.last_of_run));
         end else begin
            w = owed_words.pop_front();
            if (rsp_data.action !== w.action)
               report($sformatf("action %0d, want %0d", rsp_data.action, w.action));
            if (rsp_data.target_tile !== w.target_tile)
               report($sformatf("target_tile %0d, want %0d",
                                rsp_data.target_tile, w.target_tile));
            if (rsp_data.last_of_run !== w.last_of_run)
               report($sformatf("last_of_run %0b, want %0b",
                                rsp_data.last_of_run, w.last_of_run));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   function automatic req_type make_cmd(input logic [1:0] cmd, input int x, input int y,
                                        input int z, input bit v, input bit a, input int idx);
      req_type r;
      r.command       = cmd;
      r.pos_x         = x[CoordBits-1:0];
      r.pos_y         = y[CoordBits-1:0];
      r.pos_z         = z[CoordBits-1:0];
      r.view_valid    = v;
      r.asset_present = a;
      r.tile_index    = idx[TileBits-1:0];
      return r;
   endfunction

   // coordinate near the origin, or anywhere now and then
   function automatic int pick_coord(input int span);
      if ($urandom_range(0, 9) == 0) return int'($urandom());
      return $urandom_range(0, 2 * span) - span;
   endfunction

   task automatic csr_write(input logic [CsrIdxBits-1:0] idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[RadiusBits-1:0];
      case (idx)
         CSR_LOAD_RADIUS:   sh_load_radius   = value[RadiusBits-1:0];
         CSR_UNLOAD_RADIUS: sh_unload_radius = value[RadiusBits-1:0];
         CSR_ASYNC_LOAD:    sh_async         = value[0];
         default:           sh_every         = value[PhaseBits-1:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (cmd_queue.size() != 0 || start || owed_words.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // one stretch of random traffic; mostly appends and ticks near the view
   task automatic random_burst(input int n, input int span);
      int r, tiles;
      tiles = sh_count;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            cmd_queue.push_back(make_cmd(CMD_CLEAR, int'($urandom()), int'($urandom()),
                                         int'($urandom()), $urandom_range(0, 1),
                                         $urandom_range(0, 1), $urandom_range(0, 31)));
            tiles = 0;
         end else if (r < 38) begin
            cmd_queue.push_back(make_cmd(CMD_APPEND, pick_coord(span), pick_coord(span),
                                         pick_coord(span), $urandom_range(0, 1),
                                         $urandom_range(0, 6) != 0, $urandom_range(0, 31)));
            if (tiles < MaxTiles) tiles++;
         end else if (r < 75) begin
            cmd_queue.push_back(make_cmd(CMD_TICK, pick_coord(span), pick_coord(span),
                                         pick_coord(span), $urandom_range(0, 9) != 0,
                                         $urandom_range(0, 1), $urandom_range(0, 31)));
         end else begin
            // finish mostly on a live index, sometimes past the table
            cmd_queue.push_back(make_cmd(CMD_FINISH, pick_coord(span), pick_coord(span),
                                         pick_coord(span), $urandom_range(0, 5) != 0,
                                         $urandom_range(0, 1),
                                         ($urandom_range(0, 5) == 0 || tiles == 0) ?
                                         $urandom_range(0, 31) : $urandom_range(0, tiles - 1)));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part under reset settings: load and unload radius zero
      cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 1, 1, 0));             // empty table
      cmd_queue.push_back(make_cmd(CMD_APPEND, 0, 0, 0, 0, 1, 0));
      cmd_queue.push_back(make_cmd(CMD_APPEND, 8388607, -8388608, 8388607, 1, 0, 31));
      cmd_queue.push_back(make_cmd(CMD_APPEND, -8388608, 8388607, -8388608, 1, 1, 0));
      cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0));             // no view
      cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 1, 0, 0));             // begin tile 0
      cmd_queue.push_back(make_cmd(CMD_FINISH, 8388607, 8388607, 8388607, 1, 0, 0)); // drop
      cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 1, 0, 0));
      cmd_queue.push_back(make_cmd(CMD_FINISH, -8388608, 0, 0, 0, 0, 0));    // load, no view
      cmd_queue.push_back(make_cmd(CMD_FINISH, 0, 0, 0, 1, 0, 0));           // already loaded
      cmd_queue.push_back(make_cmd(CMD_FINISH, 0, 0, 0, 1, 0, 31));          // bad index
      cmd_queue.push_back(make_cmd(CMD_FINISH, 0, 0, 0, 1, 0, 1));           // no asset
      cmd_queue.push_back(make_cmd(CMD_TICK, 8388607, -8388608, 8388607, 1, 1, 0)); // unload, no asset
      cmd_queue.push_back(make_cmd(CMD_TICK, -8388608, 8388607, -8388608, 1, 1, 31));
      cmd_queue.push_back(make_cmd(CMD_FINISH, 5, 5, 5, 0, 1, 2));           // pending load done
      cmd_queue.push_back(make_cmd(CMD_FINISH, 1, 1, 1, 1, 1, 2));           // finish again
      cmd_queue.push_back(make_cmd(CMD_APPEND, 0, 0, 0, 1, 1, 0));
      cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 1, 1, 0));             // tie: later index
      cmd_queue.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 1, 1, 0));            // clear, no tile loaded
      cmd_queue.push_back(make_cmd(CMD_CLEAR, -1, -1, -1, 1, 1, 31));
      drain();

      // settings sweep, extremes included; gaps off in a couple of phases
      for (int p = 0; p < 7; p++) begin
         int lr, ur, asy, ev, span;
         case (p)
            0: begin lr = 3000; ur = 2500; asy = 1; ev = 1; span = 5000; end
            1: begin lr = 3000; ur = 4000; asy = 0; ev = 0; span = 5000; end
            2: begin lr = 2000; ur = 2000; asy = 1; ev = 3; span = 4000; end
            3: begin lr = 16777215; ur = 16777215; asy = 1; ev = 255; span = 8388607; end
            4: begin lr = 0; ur = 0; asy = 0; ev = 2; span = 3; end
            5: begin lr = 5000; ur = 1000; asy = 1; ev = 1; span = 6000; end
            default: begin lr = 16777215; ur = 0; asy = 0; ev = 1; span = 8388607; end
         endcase
         no_gaps = (p == 2 || p == 5);
         csr_write(CSR_LOAD_RADIUS, lr);
         csr_write(CSR_UNLOAD_RADIUS, ur);
         csr_write(CSR_ASYNC_LOAD, asy);
         csr_write(CSR_UPDATE_EVERY, ev);
         // table starts empty for a good share of the phases
         if (p % 2 == 0) cmd_queue.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
         random_burst(42, span);
         drain();
      end

      $display("covered %0d commands and %0d result words over 8 register settings",
               cmds_taken, words_seen);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches", error_count);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
